// ===== hdl/chd_pkg.sv =====
`default_nettype none

package chd_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;

  localparam int ATAN_N     = 24;
  localparam int ATAN_IDX_W = 5;

  localparam int DATA_W    = 16;
  localparam int DV_W      = 17;
  localparam int CW        = 20;
  localparam int ZW        = 26;
  localparam int PW        = 33;
  localparam int SW        = 18;
  localparam int HW        = 16;
  localparam int REM_W     = 24;
  localparam int Q_W       = 8;
  localparam int RECIP_W   = 25;
  localparam int MP_W      = 49;
  localparam int DEG_W     = 9;
  localparam int DB_W      = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECLINATION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd3;

  localparam logic signed [DATA_W-1:0] X_OFFSET_RST    = 16'sd114;
  localparam logic signed [DATA_W-1:0] Y_OFFSET_RST    = -16'sd34;
  localparam logic signed [DATA_W-1:0] DECLINATION_RST = 16'sd23;
  localparam logic [DB_W-1:0]          DEADBAND_RST    = 6'd3;

  localparam logic signed [ZW-1:0] DEG90_FIX  = 26'sd5898240;
  localparam logic signed [SW-1:0] FULL_TURN  = 18'sd36000;
  localparam logic [HW-1:0]        SEG_SPLIT  = 16'd24000;
  localparam logic [REM_W-1:0]     SEG1_MUL   = 24'd358;
  localparam logic [REM_W-1:0]     SEG1_BIAS  = 24'd23900;
  localparam logic [REM_W-1:0]     SEG2_MUL   = 24'd6;
  localparam logic [REM_W-1:0]     SEG2_BIAS  = 24'd200;
  localparam logic [DEG_W-1:0]     SEG2_BASE  = 9'd180;

  // floor(n / 47800) and floor(n / 400), exact for any 24 bit n
  localparam logic [RECIP_W-1:0]   SEG1_RECIP = 25'd23002336;
  localparam int                   SEG1_SHIFT = 40;
  localparam logic [RECIP_W-1:0]   SEG2_RECIP = 25'd21474837;
  localparam int                   SEG2_SHIFT = 33;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,
    ST_ROT,
    ST_SCALE,
    ST_WRAP_A,
    ST_WRAP_B,
    ST_NUM,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic logic [ZW-1:0] atan_fix(input logic [ATAN_IDX_W-1:0] i);
    logic [ZW-1:0] v;
    case (i)
      5'd0:    v = 26'd2949120;
      5'd1:    v = 26'd1740967;
      5'd2:    v = 26'd919879;
      5'd3:    v = 26'd466945;
      5'd4:    v = 26'd234379;
      5'd5:    v = 26'd117304;
      5'd6:    v = 26'd58666;
      5'd7:    v = 26'd29335;
      5'd8:    v = 26'd14668;
      5'd9:    v = 26'd7334;
      5'd10:   v = 26'd3667;
      5'd11:   v = 26'd1833;
      5'd12:   v = 26'd917;
      5'd13:   v = 26'd458;
      5'd14:   v = 26'd229;
      5'd15:   v = 26'd115;
      5'd16:   v = 26'd57;
      5'd17:   v = 26'd29;
      5'd18:   v = 26'd14;
      5'd19:   v = 26'd7;
      5'd20:   v = 26'd4;
      5'd21:   v = 26'd2;
      5'd22:   v = 26'd1;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/compass_heading_deadband_unit.sv =====
// From input accept to out_valid the sequencer steps through PRE, the CORDIC
// iterations in ROT (skipped when the offset-corrected vector is zero), then
// SCALE, WRAP_A, WRAP_B, NUM, DIV and DONE. The shared CORDIC rotator (one
// iteration a cycle) takes one item at a time; a stalled result holds the sequencer.
// Reset (rst_n low, synchronous): sequencer idle, output empty, previous
// heading 0, configuration registers at their default values.
`default_nettype none

module compass_heading_deadband_unit #(
  parameter int CORDIC_ITERATIONS = chd_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,

  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire signed [chd_pkg::DATA_W-1:0]       in_x_raw,
  input  wire signed [chd_pkg::DATA_W-1:0]       in_y_raw,

  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic [chd_pkg::HW-1:0]                 out_heading_centideg,
  output logic [chd_pkg::DEG_W-1:0]              out_smooth_heading_deg,

  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [chd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire [chd_pkg::DATA_W-1:0]              cfg_data
);

  localparam int CNT_W = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(CORDIC_ITERATIONS - 1);

  chd_pkg::state_t state_r, state_nxt;

  logic signed [chd_pkg::DATA_W-1:0] x_off_r, y_off_r, decl_r;
  logic [chd_pkg::DB_W-1:0]          db_r;

  logic signed [chd_pkg::CW-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [chd_pkg::ZW-1:0]  z_r, z_nxt;
  logic [CNT_W-1:0]               iter_r, iter_nxt;
  logic signed [chd_pkg::SW-1:0]  s_r, s_nxt;
  logic                           seg2_r, seg2_nxt;
  logic [chd_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [chd_pkg::Q_W-1:0]        q_r, q_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [chd_pkg::HW-1:0]         heading_r, heading_nxt;
  logic [chd_pkg::DEG_W-1:0]      last_r, last_nxt;

  logic signed [chd_pkg::DV_W-1:0] dx, dy;
  logic signed [chd_pkg::CW-1:0]   xs, ys;
  logic signed [chd_pkg::ZW-1:0]   atan_v;
  logic signed [chd_pkg::PW-1:0]   prod, rnd;
  logic signed [chd_pkg::SW-1:0]   cd, s_wrap;
  logic [chd_pkg::HW-1:0]          h;
  logic [chd_pkg::RECIP_W-1:0]     recip;
  logic [chd_pkg::MP_W-1:0]        qprod;
  logic [chd_pkg::Q_W-1:0]         quot;
  logic [chd_pkg::DEG_W-1:0]       corr, diff;
  logic                            keep;
  logic                            out_go;

  assign in_stall               = (state_r != chd_pkg::ST_IDLE);
  assign cfg_ready              = 1'b1;
  assign out_valid              = out_valid_r;
  assign out_heading_centideg   = heading_r;
  assign out_smooth_heading_deg = last_r;

  assign dx = $signed({in_x_raw[chd_pkg::DATA_W-1], in_x_raw})
            - $signed({x_off_r[chd_pkg::DATA_W-1], x_off_r});
  assign dy = $signed({in_y_raw[chd_pkg::DATA_W-1], in_y_raw})
            - $signed({y_off_r[chd_pkg::DATA_W-1], y_off_r});

  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign atan_v = $signed(chd_pkg::atan_fix(chd_pkg::ATAN_IDX_W'(iter_r)));

  assign prod = chd_pkg::PW'(z_r) * 33'sd100;
  assign rnd  = prod + 33'sd32768;
  assign cd   = chd_pkg::SW'(rnd >>> 16);

  assign s_wrap = s_r[chd_pkg::SW-1] ? s_r + chd_pkg::FULL_TURN
                : (s_r >= chd_pkg::FULL_TURN) ? s_r - chd_pkg::FULL_TURN : s_r;

  assign h = s_r[chd_pkg::HW-1:0];

  assign recip = seg2_r ? chd_pkg::SEG2_RECIP : chd_pkg::SEG1_RECIP;
  assign qprod = chd_pkg::MP_W'(rem_r) * chd_pkg::MP_W'(recip);
  assign quot  = seg2_r ? qprod[chd_pkg::SEG2_SHIFT +: chd_pkg::Q_W]
                        : qprod[chd_pkg::SEG1_SHIFT +: chd_pkg::Q_W];

  assign corr   = seg2_r ? chd_pkg::SEG2_BASE + chd_pkg::DEG_W'(q_r) : chd_pkg::DEG_W'(q_r);
  assign diff   = (corr >= last_r) ? corr - last_r : last_r - corr;
  assign keep   = (diff < chd_pkg::DEG_W'(db_r));
  assign out_go = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = chd_pkg::ST_PRE;
      end
      chd_pkg::ST_PRE: begin
        if (x_r == '0 && y_r == '0) state_nxt = chd_pkg::ST_SCALE;
        else                        state_nxt = chd_pkg::ST_ROT;
      end
      chd_pkg::ST_ROT: begin
        if (iter_r == LAST_ITER) state_nxt = chd_pkg::ST_SCALE;
      end
      chd_pkg::ST_SCALE:  state_nxt = chd_pkg::ST_WRAP_A;
      chd_pkg::ST_WRAP_A: state_nxt = chd_pkg::ST_WRAP_B;
      chd_pkg::ST_WRAP_B: state_nxt = chd_pkg::ST_NUM;
      chd_pkg::ST_NUM:    state_nxt = chd_pkg::ST_DIV;
      chd_pkg::ST_DIV:    state_nxt = chd_pkg::ST_DONE;
      chd_pkg::ST_DONE: begin
        if (out_go) state_nxt = chd_pkg::ST_IDLE;
      end
      default: state_nxt = chd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    iter_nxt      = iter_r;
    s_nxt         = s_r;
    seg2_nxt      = seg2_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    heading_nxt   = heading_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      chd_pkg::ST_IDLE: begin
        x_nxt = chd_pkg::CW'(dx);
        y_nxt = chd_pkg::CW'(dy);
      end
      chd_pkg::ST_PRE: begin
        iter_nxt = '0;
        z_nxt    = '0;
        if (x_r[chd_pkg::CW-1]) begin
          if (!y_r[chd_pkg::CW-1]) begin
            x_nxt = y_r;
            y_nxt = -x_r;
            z_nxt = chd_pkg::DEG90_FIX;
          end else begin
            x_nxt = -y_r;
            y_nxt = x_r;
            z_nxt = -chd_pkg::DEG90_FIX;
          end
        end
      end
      chd_pkg::ST_ROT: begin
        iter_nxt = iter_r + 1'b1;
        if (!y_r[chd_pkg::CW-1]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + atan_v;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - atan_v;
        end
      end
      chd_pkg::ST_SCALE: begin
        s_nxt = cd + chd_pkg::SW'(decl_r);
      end
      chd_pkg::ST_WRAP_A, chd_pkg::ST_WRAP_B: begin
        s_nxt = s_wrap;
      end
      chd_pkg::ST_NUM: begin
        seg2_nxt = (h >= chd_pkg::SEG_SPLIT);
        q_nxt    = '0;
        if (h >= chd_pkg::SEG_SPLIT)
          rem_nxt = chd_pkg::REM_W'(h - chd_pkg::SEG_SPLIT) * chd_pkg::SEG2_MUL
                  + chd_pkg::SEG2_BIAS;
        else
          rem_nxt = chd_pkg::REM_W'(h) * chd_pkg::SEG1_MUL + chd_pkg::SEG1_BIAS;
      end
      chd_pkg::ST_DIV: begin
        q_nxt = quot;
      end
      chd_pkg::ST_DONE: begin
        if (out_go) begin
          out_valid_nxt = 1'b1;
          heading_nxt   = h;
          last_nxt      = keep ? last_r : corr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
      x_off_r     <= chd_pkg::X_OFFSET_RST;
      y_off_r     <= chd_pkg::Y_OFFSET_RST;
      decl_r      <= chd_pkg::DECLINATION_RST;
      db_r        <= chd_pkg::DEADBAND_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          chd_pkg::REG_X_OFFSET:    x_off_r <= $signed(cfg_data);
          chd_pkg::REG_Y_OFFSET:    y_off_r <= $signed(cfg_data);
          chd_pkg::REG_DECLINATION: decl_r  <= $signed(cfg_data);
          chd_pkg::REG_DEADBAND:    db_r    <= cfg_data[chd_pkg::DB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    z_r       <= z_nxt;
    iter_r    <= iter_nxt;
    s_r       <= s_nxt;
    seg2_r    <= seg2_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    heading_r <= heading_nxt;
  end

endmodule

`default_nettype wire
